>>> hdl/rlu_pkg.sv
// shared types, register indexes and constants of the regression loss unit
`default_nettype none

package rlu_pkg;

  // widths of the item fields
  localparam int DataW  = 16;
  localparam int ResW   = 48;
  localparam int CountW = 25;
  localparam int DiffW  = DataW + 1;
  localparam int OpAW   = DataW + 2;
  localparam int OpBW   = DataW + 1;
  localparam int ProdW  = OpAW + OpBW;

  // configuration port
  localparam int CfgAddrW = 3;
  localparam int CfgDataW = CountW;

  localparam logic [CfgAddrW-1:0] REG_LOSS_KIND      = 3'd0;
  localparam logic [CfgAddrW-1:0] REG_BACKWARD_MODE  = 3'd1;
  localparam logic [CfgAddrW-1:0] REG_REDUCTION_MODE = 3'd2;
  localparam logic [CfgAddrW-1:0] REG_GRAD_SCALE     = 3'd3;
  localparam logic [CfgAddrW-1:0] REG_ELEMENT_COUNT  = 3'd4;

  // loss kinds (code three behaves as smooth l1)
  localparam logic [1:0] KIND_SQ     = 2'd0;
  localparam logic [1:0] KIND_ABS    = 2'd1;
  localparam logic [1:0] KIND_SMOOTH = 2'd2;

  // reductions (code three behaves as sum)
  localparam logic [1:0] RED_NONE = 2'd0;
  localparam logic [1:0] RED_MEAN = 2'd1;
  localparam logic [1:0] RED_SUM  = 2'd2;

  // fixed point constants
  localparam logic [CountW-1:0] MAX_ELEMENTS = 25'd16777216;
  localparam logic signed [DiffW-1:0] ONE_Q8 = 17'sd256;
  localparam logic signed [DiffW-1:0] NEG_ONE_Q8 = -17'sd256;
  localparam logic [DataW-1:0] ONE_Q8_MAG = 16'd256;
  localparam logic signed [ProdW-1:0] HALF_Q16 = 35'sd32768;
  localparam logic signed [ResW-1:0] RES_HI = {1'b0, {(ResW-1){1'b1}}};
  localparam logic signed [ResW-1:0] RES_LO = {1'b1, {(ResW-1){1'b0}}};

  // input transaction
  typedef struct packed {
    logic signed [DataW-1:0] prediction;
    logic signed [DataW-1:0] target_value;
    logic signed [DataW-1:0] upstream_grad;
    logic                    last_element;
  } in_item_t;

  // result transaction
  typedef struct packed {
    logic signed [ResW-1:0] result_value;
    logic                   last_of_run;
    logic                   saturated;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic mul;
    logic post;
    logic div_start;
    logic out_load;
  } rlu_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic post_result;
    logic post_div;
    logic div_busy;
    logic out_free;
  } rlu_sts_t;

endpackage

`default_nettype wire

>>> hdl/regression_loss_unit.sv
// top level of the regression loss unit: controller, datapath and ports
//
// Usage:
//   Input transactions carry prediction, target_value and upstream_grad in
//   signed Q8.8 plus last_element; results carry result_value with 16
//   fraction bits, last_of_run and saturated. Both channels use valid/stall.
//   Configuration is a plain write port (cfg_we, cfg_addr, cfg_wdata); the
//   user writes it only while no element is in flight, and the block itself
//   does not enforce this. An element goes through the steps register,
//   multiply, accumulate/clip, write to the output register before the next
//   can be taken.
//   Where a mean division is needed (the last element of a mean forward
//   run, or every element of a mean backward run) the shared 48-step serial
//   divider runs before the write step, one quotient bit per cycle.
//   Reduced forward elements not marked last give no result.
//   The output register is separate from the element pipeline, so a new
//   element is taken while a result waits; if the receiver stalls, the next
//   result holds in the write step until the register frees.
//   Reset (rst_n low, synchronous) restores the configuration defaults,
//   clears running sum, element count and clip flag, and empties the output.
`default_nettype none

module regression_loss_unit (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire rlu_pkg::in_item_t                in_data,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output rlu_pkg::out_item_t                    out_data,
  input  wire logic                             cfg_we,
  input  wire logic [rlu_pkg::CfgAddrW-1:0]     cfg_addr,
  input  wire logic [rlu_pkg::CfgDataW-1:0]     cfg_wdata
);

  rlu_pkg::rlu_cmd_t cmd;
  rlu_pkg::rlu_sts_t sts;

  // sequencing
  rlu_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // arithmetic and storage
  rlu_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

endmodule

`default_nettype wire

>>> hdl/rlu_div.sv
// iterative signed by unsigned divider, one quotient bit per cycle
`default_nettype none

module rlu_div (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 start,
  input  wire logic signed [rlu_pkg::ResW-1:0]      num,
  input  wire logic        [rlu_pkg::CountW-1:0]    den,
  output logic                                      busy,
  output logic signed [rlu_pkg::ResW-1:0]           quotient
);

  localparam int CntW = $clog2(rlu_pkg::ResW + 1);

  logic [CntW-1:0]             cnt_r;
  logic                        neg_r;
  logic [rlu_pkg::ResW-1:0]    quo_r;
  logic [rlu_pkg::CountW-1:0]  rem_r;
  logic [rlu_pkg::CountW-1:0]  den_r;
  logic [rlu_pkg::CountW:0]    rem_sh;
  logic [rlu_pkg::CountW:0]    rem_sub;
  logic [rlu_pkg::ResW-1:0]    num_mag;

  assign num_mag = num[rlu_pkg::ResW-1] ? (~num + 1'b1) : num;

  // shift in the next dividend bit and try the subtraction
  assign rem_sh  = {rem_r, quo_r[rlu_pkg::ResW-1]};
  assign rem_sub = rem_sh - {1'b0, den_r};

  // iteration counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= CntW'(rlu_pkg::ResW);
    end else if (cnt_r != '0) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  // restoring division step
  always_ff @(posedge clk) begin
    if (start) begin
      neg_r <= num[rlu_pkg::ResW-1];
      quo_r <= num_mag;
      rem_r <= '0;
      den_r <= den;
    end else if (cnt_r != '0) begin
      if (!rem_sub[rlu_pkg::CountW]) begin
        rem_r <= rem_sub[rlu_pkg::CountW-1:0];
        quo_r <= {quo_r[rlu_pkg::ResW-2:0], 1'b1};
      end else begin
        rem_r <= rem_sh[rlu_pkg::CountW-1:0];
        quo_r <= {quo_r[rlu_pkg::ResW-2:0], 1'b0};
      end
    end
  end

  assign busy     = (cnt_r != '0);
  assign quotient = neg_r ? -$signed(quo_r) : $signed(quo_r);

endmodule

`default_nettype wire

>>> hdl/rlu_dpath.sv
// datapath: configuration registers, multiplier stage, accumulation and result register
`default_nettype none

module rlu_dpath (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire rlu_pkg::rlu_cmd_t               cmd,
  output rlu_pkg::rlu_sts_t                    sts,
  input  wire rlu_pkg::in_item_t               in_data,
  input  wire logic                            out_stall,
  output logic                                 out_valid,
  output rlu_pkg::out_item_t                   out_data,
  input  wire logic                            cfg_we,
  input  wire logic [rlu_pkg::CfgAddrW-1:0]    cfg_addr,
  input  wire logic [rlu_pkg::CfgDataW-1:0]    cfg_wdata
);

  // configuration registers
  logic [1:0]                          loss_kind_r;
  logic                                backward_mode_r;
  logic [1:0]                          reduction_mode_r;
  logic signed [rlu_pkg::DataW-1:0]    grad_scale_r;
  logic [rlu_pkg::CountW-1:0]          element_count_r;

  // run state
  logic signed [rlu_pkg::ResW-1:0]     run_sum_r;
  logic [rlu_pkg::CountW-1:0]          item_count_r;
  logic signed [rlu_pkg::OpBW-1:0]     grad_norm_r;
  logic                                run_clipped_r;

  // item pipeline
  rlu_pkg::in_item_t                   in_r;
  logic signed [rlu_pkg::ProdW-1:0]    prod_r;
  logic [rlu_pkg::DataW-1:0]           abs_r;
  logic signed [rlu_pkg::ResW-1:0]     stage_val_r;
  logic                                stage_sat_r;
  logic                                stage_last_r;
  logic [rlu_pkg::CountW-1:0]          stage_den_r;
  logic                                use_div_r;
  logic                                out_valid_r;
  rlu_pkg::out_item_t                  out_data_r;

  logic [1:0]                          kind;
  logic                                red_none;
  logic                                red_mean;
  logic signed [rlu_pkg::DiffW-1:0]    diff;
  logic [rlu_pkg::DataW-1:0]           diff_abs;
  logic signed [rlu_pkg::DiffW-1:0]    diff_clamp;
  logic signed [rlu_pkg::DiffW-1:0]    sign_one;
  logic signed [rlu_pkg::OpBW-1:0]     gs_norm;
  logic signed [rlu_pkg::OpBW-1:0]     gn_now;
  logic signed [rlu_pkg::OpAW-1:0]     op_a;
  logic signed [rlu_pkg::OpBW-1:0]     op_b;
  logic signed [rlu_pkg::ProdW-1:0]    prod_nxt;
  logic signed [rlu_pkg::ProdW-1:0]    abs_q16;
  logic signed [rlu_pkg::ProdW-1:0]    loss;
  logic signed [rlu_pkg::ResW-1:0]     val48;
  logic signed [rlu_pkg::ResW:0]       sum_wide;
  logic signed [rlu_pkg::ResW-1:0]     sum_clip;
  logic                                sum_sat;
  logic [rlu_pkg::CountW-1:0]          cnt_inc;
  logic [rlu_pkg::CountW-1:0]          den_bwd;
  logic                                div_busy;
  logic signed [rlu_pkg::ResW-1:0]     div_q;

  // mode decode
  assign kind     = (loss_kind_r == 2'd3) ? rlu_pkg::KIND_SMOOTH : loss_kind_r;
  assign red_none = (reduction_mode_r == rlu_pkg::RED_NONE);
  assign red_mean = (reduction_mode_r == rlu_pkg::RED_MEAN);

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loss_kind_r      <= rlu_pkg::KIND_SQ;
      backward_mode_r  <= 1'b0;
      reduction_mode_r <= rlu_pkg::RED_MEAN;
      grad_scale_r     <= 16'sd256;
      element_count_r  <= 25'd1;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        rlu_pkg::REG_LOSS_KIND:      loss_kind_r      <= cfg_wdata[1:0];
        rlu_pkg::REG_BACKWARD_MODE:  backward_mode_r  <= cfg_wdata[0];
        rlu_pkg::REG_REDUCTION_MODE: reduction_mode_r <= cfg_wdata[1:0];
        rlu_pkg::REG_GRAD_SCALE:     grad_scale_r     <= cfg_wdata[rlu_pkg::DataW-1:0];
        rlu_pkg::REG_ELEMENT_COUNT:  element_count_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      in_r <= in_data;
    end
  end

  // difference, clamp and gradient scale
  always_comb begin
    diff     = {in_r.prediction[rlu_pkg::DataW-1], in_r.prediction}
             - {in_r.target_value[rlu_pkg::DataW-1], in_r.target_value};
    diff_abs = diff[rlu_pkg::DiffW-1] ? rlu_pkg::DataW'(-diff) : diff[rlu_pkg::DataW-1:0];
    if (diff > rlu_pkg::ONE_Q8) begin
      diff_clamp = rlu_pkg::ONE_Q8;
    end else if (diff < rlu_pkg::NEG_ONE_Q8) begin
      diff_clamp = rlu_pkg::NEG_ONE_Q8;
    end else begin
      diff_clamp = diff;
    end
    sign_one = diff[rlu_pkg::DiffW-1] ? rlu_pkg::NEG_ONE_Q8 : rlu_pkg::ONE_Q8;
    gs_norm  = (kind == rlu_pkg::KIND_SQ) ? {grad_scale_r, 1'b0}
                                          : {grad_scale_r[rlu_pkg::DataW-1], grad_scale_r};
    gn_now   = (item_count_r == '0) ? gs_norm : grad_norm_r;
  end

  // multiplier operand selection
  always_comb begin
    if (!backward_mode_r) begin
      op_a = {diff[rlu_pkg::DiffW-1], diff};
      op_b = diff;
    end else begin
      op_b = red_none ? {in_r.upstream_grad[rlu_pkg::DataW-1], in_r.upstream_grad} : gn_now;
      case (kind)
        rlu_pkg::KIND_SQ: op_a = red_none ? {diff, 1'b0} : {diff[rlu_pkg::DiffW-1], diff};
        rlu_pkg::KIND_ABS: op_a = {sign_one[rlu_pkg::DiffW-1], sign_one};
        default: op_a = {diff_clamp[rlu_pkg::DiffW-1], diff_clamp};
      endcase
    end
    prod_nxt = op_a * op_b;
  end

  // multiplier stage
  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod_r <= prod_nxt;
      abs_r  <= diff_abs;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grad_norm_r <= '0;
    end else if (cmd.mul && backward_mode_r && !red_none) begin
      grad_norm_r <= gn_now;
    end
  end

  // loss value and running sum
  always_comb begin
    abs_q16 = rlu_pkg::ProdW'({abs_r, 8'h00});
    if (backward_mode_r) begin
      loss = prod_r;
    end else begin
      case (kind)
        rlu_pkg::KIND_SQ: loss = prod_r;
        rlu_pkg::KIND_ABS: loss = abs_q16;
        default: loss = (abs_r < rlu_pkg::ONE_Q8_MAG) ? (prod_r >>> 1)
                                                      : (abs_q16 - rlu_pkg::HALF_Q16);
      endcase
    end
    val48    = {{(rlu_pkg::ResW-rlu_pkg::ProdW){loss[rlu_pkg::ProdW-1]}}, loss};
    sum_wide = {run_sum_r[rlu_pkg::ResW-1], run_sum_r} + {val48[rlu_pkg::ResW-1], val48};
    sum_sat  = (sum_wide[rlu_pkg::ResW] != sum_wide[rlu_pkg::ResW-1]);
    if (!sum_sat) begin
      sum_clip = sum_wide[rlu_pkg::ResW-1:0];
    end else if (sum_wide[rlu_pkg::ResW]) begin
      sum_clip = rlu_pkg::RES_LO;
    end else begin
      sum_clip = rlu_pkg::RES_HI;
    end
    cnt_inc = (item_count_r == rlu_pkg::MAX_ELEMENTS) ? item_count_r : item_count_r + 1'b1;
    den_bwd = (element_count_r == '0) ? rlu_pkg::CountW'(1) : element_count_r;
  end

  // run state update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_sum_r     <= '0;
      item_count_r  <= '0;
      run_clipped_r <= 1'b0;
    end else if (cmd.post && !red_none) begin
      item_count_r <= in_r.last_element ? '0 : cnt_inc;
      if (!backward_mode_r) begin
        run_sum_r     <= in_r.last_element ? '0 : sum_clip;
        run_clipped_r <= in_r.last_element ? 1'b0 : (run_clipped_r | sum_sat);
      end else if (in_r.last_element) begin
        run_clipped_r <= 1'b0;
      end
    end
  end

  // result staging
  always_ff @(posedge clk) begin
    if (cmd.post) begin
      stage_last_r <= in_r.last_element;
      use_div_r    <= sts.post_div;
      if (!backward_mode_r && !red_none) begin
        stage_val_r <= sum_clip;
        stage_sat_r <= run_clipped_r | sum_sat;
        stage_den_r <= cnt_inc;
      end else begin
        stage_val_r <= val48;
        stage_sat_r <= 1'b0;
        stage_den_r <= den_bwd;
      end
    end
  end

  rlu_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .num      (stage_val_r),
    .den      (stage_den_r),
    .busy     (div_busy),
    .quotient (div_q)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r.result_value <= use_div_r ? div_q : stage_val_r;
      out_data_r.last_of_run  <= stage_last_r;
      out_data_r.saturated    <= stage_sat_r;
    end
  end

  // status to the controller
  always_comb begin
    sts.post_result = red_none || backward_mode_r || in_r.last_element;
    sts.post_div    = red_mean && (backward_mode_r || in_r.last_element);
    sts.div_busy    = div_busy;
    sts.out_free    = !out_valid_r || !out_stall;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

>>> hdl/rlu_ctrl.sv
// controller: sequences one element through the datapath
`default_nettype none

module rlu_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire rlu_pkg::rlu_sts_t sts,
  output rlu_pkg::rlu_cmd_t      cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_POST,
    S_DIV,
    S_WAIT,
    S_OUT
  } state_t;

  state_t state_r;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      unique case (state_r)
        S_IDLE: if (in_valid) state_r <= S_MUL;
        S_MUL:  state_r <= S_POST;
        S_POST: begin
          if (!sts.post_result) begin
            state_r <= S_IDLE;
          end else if (sts.post_div) begin
            state_r <= S_DIV;
          end else begin
            state_r <= S_OUT;
          end
        end
        S_DIV:  state_r <= S_WAIT;
        S_WAIT: if (!sts.div_busy) state_r <= S_OUT;
        S_OUT:  if (sts.out_free) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // command decode
  always_comb begin
    in_stall      = (state_r != S_IDLE);
    cmd.load      = (state_r == S_IDLE) && in_valid;
    cmd.mul       = (state_r == S_MUL);
    cmd.post      = (state_r == S_POST);
    cmd.div_start = (state_r == S_DIV);
    cmd.out_load  = (state_r == S_OUT) && sts.out_free;
  end

endmodule

`default_nettype wire
